/* rtl/sdcd_pkg.sv */
`default_nettype none

package sdcd_pkg;

  localparam int FRAME_KEEP_BYTES_DEF = 12;
  localparam int DECODE_BYTES = 12;
  localparam int LEN_W = 4;
  localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;

  localparam logic [7:0] FEND = 8'hC0;
  localparam logic [7:0] FESC = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;
  localparam logic [7:0] CMD_CHAR = 8'hFD;
  localparam logic [7:0] CMD_RECT = 8'hFE;
  localparam logic [7:0] CMD_SYS = 8'hFF;

  localparam int TDATA_IN_W = 8;
  localparam int TUSER_IN_W = 1;
  localparam int TDATA_OUT_W = 168;
  localparam int TUSER_OUT_W = 2;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_RECT = 2'd1,
    KIND_SYS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_ERASE_BLACK = 2'd1,
    ACT_HIGHLIGHT   = 2'd2
  } action_t;

  typedef struct packed {
    logic [LEN_W-1:0]                len;
    logic [DECODE_BYTES-1:0][7:0]    bytes;
  } frame_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  glyph;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [23:0] fore_color;
    logic [23:0] back_color;
    action_t     region_action;
    logic [7:0]  hardware_kind;
    logic [23:0] firmware_version;
    logic [7:0]  font_setting;
  } result_t;

endpackage

`default_nettype wire

/* rtl/sdcd_deframer.sv */
`default_nettype none

module sdcd_deframer
  import sdcd_pkg::*;
#(
  parameter int FRAME_KEEP_BYTES = FRAME_KEEP_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       drop_frame,
  output frame_t          frm,
  output logic            frm_valid,
  input  wire logic       frm_take
);

  localparam int IDX_W = $clog2(FRAME_KEEP_BYTES);

  logic [7:0]       store [FRAME_KEEP_BYTES];
  logic [LEN_W-1:0] frame_length;
  logic             escape_pending;
  logic             accept;
  logic             push;
  logic             close;
  logic [7:0]       push_byte;

  assign in_ready = !frm_valid || frm_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push      = 1'b0;
    close     = 1'b0;
    push_byte = rx_byte;
    if (accept && !drop_frame) begin
      if (escape_pending) begin
        push = 1'b1;
        if (rx_byte == TFEND) begin
          push_byte = FEND;
        end else if (rx_byte == TFESC) begin
          push_byte = FESC;
        end
      end else if (rx_byte == FEND) begin
        close = (frame_length != '0);
      end else if (rx_byte != FESC) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length   <= '0;
      escape_pending <= 1'b0;
      frm_valid      <= 1'b0;
    end else begin
      frm_valid <= (frm_valid && !frm_take) || close;
      if (accept) begin
        if (drop_frame) begin
          frame_length   <= '0;
          escape_pending <= 1'b0;
        end else if (escape_pending) begin
          escape_pending <= 1'b0;
          if (frame_length != LEN_MAX) begin
            frame_length <= frame_length + 1'b1;
          end
        end else if (rx_byte == FESC) begin
          escape_pending <= 1'b1;
        end else if (rx_byte == FEND) begin
          frame_length <= '0;
        end else if (frame_length != LEN_MAX) begin
          frame_length <= frame_length + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (int'(frame_length) < FRAME_KEEP_BYTES)) begin
      store[IDX_W'(frame_length)] <= push_byte;
    end
    if (close) begin
      frm.len <= frame_length;
      for (int i = 0; i < DECODE_BYTES; i++) begin
        frm.bytes[i] <= store[i];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sdcd_decoder.sv */
`default_nettype none

module sdcd_decoder
  import sdcd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire frame_t frm,
  input  wire logic   frm_valid,
  output logic        frm_take,
  output result_t     res,
  output logic        res_valid,
  input  wire logic   res_ready
);

  logic [23:0] last_rect_color;
  logic [23:0] last_rect_color_next;
  logic [7:0]  stored_hardware_kind;
  logic [7:0]  stored_hardware_kind_next;
  logic [23:0] stored_firmware_version;
  logic [23:0] stored_firmware_version_next;
  logic [7:0]  stored_font_setting;
  logic [7:0]  stored_font_setting_next;
  result_t     res_next;
  logic        has_res;
  logic [7:0]  b [DECODE_BYTES];
  logic [15:0] w;
  logic [15:0] h;
  logic [23:0] col;

  always_comb begin
    for (int i = 0; i < DECODE_BYTES; i++) begin
      b[i] = frm.bytes[i];
    end
  end

  assign frm_take = frm_valid && (!res_valid || res_ready);

  always_comb begin
    last_rect_color_next         = last_rect_color;
    stored_hardware_kind_next    = stored_hardware_kind;
    stored_firmware_version_next = stored_firmware_version;
    stored_font_setting_next     = stored_font_setting;
    has_res = 1'b0;
    w       = 16'd1;
    h       = 16'd1;
    col     = last_rect_color;
    res_next = '0;
    case (b[0])
      CMD_CHAR: begin
        has_res = (frm.len >= LEN_W'(12));
        res_next.kind       = KIND_CHAR;
        res_next.glyph      = b[1];
        res_next.pos_x      = {b[3], b[2]};
        res_next.pos_y      = {b[5], b[4]};
        res_next.fore_color = {b[6], b[7], b[8]};
        res_next.back_color = {b[9], b[10], b[11]};
      end
      CMD_RECT: begin
        has_res = (frm.len >= LEN_W'(5));
        if (frm.len == LEN_W'(8)) begin
          col = {b[5], b[6], b[7]};
        end else if (frm.len == LEN_W'(9)) begin
          w = {b[6], b[5]};
          h = {b[8], b[7]};
        end else if (frm.len >= LEN_W'(12)) begin
          w   = {b[6], b[5]};
          h   = {b[8], b[7]};
          col = {b[9], b[10], b[11]};
        end
        if (has_res) begin
          last_rect_color_next = col;
        end
        res_next.kind        = KIND_RECT;
        res_next.pos_x       = {b[2], b[1]};
        res_next.pos_y       = {b[4], b[3]};
        res_next.rect_width  = w;
        res_next.rect_height = h;
        res_next.fore_color  = col;
        if (w >= 16'd4 && h >= 16'd4) begin
          res_next.region_action = (col == '0) ? ACT_ERASE_BLACK : ACT_HIGHLIGHT;
        end
      end
      CMD_SYS: begin
        has_res = 1'b1;
        if (frm.len >= LEN_W'(5)) begin
          stored_hardware_kind_next    = b[1];
          stored_firmware_version_next = {b[2], b[3], b[4]};
        end
        if (frm.len >= LEN_W'(6)) begin
          stored_font_setting_next = b[5];
        end
        res_next.kind = KIND_SYS;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
    res_next.hardware_kind    = stored_hardware_kind_next;
    res_next.firmware_version = stored_firmware_version_next;
    res_next.font_setting     = stored_font_setting_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_rect_color         <= '0;
      stored_hardware_kind    <= '0;
      stored_firmware_version <= '0;
      stored_font_setting     <= '0;
      res_valid               <= 1'b0;
    end else begin
      if (frm_take) begin
        last_rect_color         <= last_rect_color_next;
        stored_hardware_kind    <= stored_hardware_kind_next;
        stored_firmware_version <= stored_firmware_version_next;
        stored_font_setting     <= stored_font_setting_next;
      end
      if (frm_take && has_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_take && has_res) begin
      res <= res_next;
    end
  end

  a_take_needs_room: assert property (@(posedge clk) disable iff (rst)
    frm_take |-> (!res_valid || res_ready))
    else $error("frame taken while the result register is still occupied");

  a_rect_color_kept: assert property (@(posedge clk) disable iff (rst)
    (frm_take && has_res && res_next.kind == KIND_RECT) |=>
      (res.fore_color == last_rect_color))
    else $error("rectangle color does not match the stored rectangle color");

  a_char_no_action: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind != KIND_RECT) |->
      (res.region_action == ACT_NONE && res.rect_width == '0 && res.rect_height == '0))
    else $error("non-rectangle item carries rectangle fields");

  a_action_size: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.region_action != ACT_NONE) |->
      (res.rect_width >= 16'd4 && res.rect_height >= 16'd4))
    else $error("region action on a rectangle smaller than four by four");

endmodule

`default_nettype wire

/* rtl/slip_display_command_decoder_unit.sv */
`default_nettype none

// SLIP display command decoder. Each slave item is one received byte (tuser
// bit 0 discards the partial frame). SLIP escapes are undone, END closes a
// frame, and each frame that decodes to a display command yields one master
// item, which passes the frame register and then the result register.
// The block takes one byte per cycle; the input stalls only when a decoded
// frame is waiting in the frame register behind a master item that has not
// been taken.

module slip_display_command_decoder_unit
  import sdcd_pkg::*;
#(
  parameter int FRAME_KEEP_BYTES = FRAME_KEEP_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [TDATA_IN_W-1:0]  s_tdata,   // rx_byte
  input  wire logic [TUSER_IN_W-1:0]  s_tuser,   // drop_frame
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // glyph, pos_x, pos_y, rect_width, rect_height, fore_color, back_color,
  // region_action, hardware_kind, firmware_version, font_setting, zero fill
  output logic [TDATA_OUT_W-1:0]      m_tdata,
  output logic [TUSER_OUT_W-1:0]      m_tuser    // kind
);

  frame_t  frm;
  logic    frm_valid;
  logic    frm_take;
  result_t res;

  sdcd_deframer #(
    .FRAME_KEEP_BYTES(FRAME_KEEP_BYTES)
  ) u_deframer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .rx_byte    (s_tdata[7:0]),
    .drop_frame (s_tuser[0]),
    .frm        (frm),
    .frm_valid  (frm_valid),
    .frm_take   (frm_take)
  );

  sdcd_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .frm       (frm),
    .frm_valid (frm_valid),
    .frm_take  (frm_take),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {6'b0, res.font_setting, res.firmware_version, res.hardware_kind,
                    res.region_action, res.back_color, res.fore_color,
                    res.rect_height, res.rect_width, res.pos_y, res.pos_x, res.glyph};

endmodule

`default_nettype wire

/* dv/display_command_checker.sv */
`timescale 1ns / 100ps

module display_command_checker
  import sdcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [TDATA_IN_W-1:0]  s_tdata,
  input  logic [TUSER_IN_W-1:0]  s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [TDATA_OUT_W-1:0] m_tdata,
  input  logic [TUSER_OUT_W-1:0] m_tuser,
  output int                     mismatches,
  output int                     pending
);

  logic [7:0]       frame_bytes [FRAME_KEEP_BYTES_DEF];
  logic [LEN_W-1:0] frame_len;
  logic             esc_pending;
  logic [23:0]      rect_color;
  logic [7:0]       hw_kind;
  logic [23:0]      fw_version;
  logic [7:0]       font_sel;
  result_t          expected_cmds[$];
  result_t          want;

  function automatic logic [7:0] frame_byte(int i);
    return (i < FRAME_KEEP_BYTES_DEF) ? frame_bytes[i] : 8'h00;
  endfunction

  function automatic logic [15:0] le16(int i);
    return {frame_byte(i + 1), frame_byte(i)};
  endfunction

  function automatic logic [23:0] be24(int i);
    return {frame_byte(i), frame_byte(i + 1), frame_byte(i + 2)};
  endfunction

  function automatic void store_byte(logic [7:0] b);
    if (frame_len < FRAME_KEEP_BYTES_DEF) frame_bytes[frame_len] = b;
    if (frame_len != LEN_MAX) frame_len++;
  endfunction

  task automatic close_frame();
    result_t     cmd;
    logic        hit;
    logic [15:0] w;
    logic [15:0] h;
    logic [23:0] col;
    cmd = '0;
    hit = 1'b0;
    case (frame_byte(0))
      CMD_CHAR: begin
        if (frame_len >= 12) begin
          hit = 1'b1;
          cmd.kind = KIND_CHAR;
          cmd.glyph = frame_byte(1);
          cmd.pos_x = le16(2);
          cmd.pos_y = le16(4);
          cmd.fore_color = be24(6);
          cmd.back_color = be24(9);
        end
      end
      CMD_RECT: begin
        if (frame_len >= 5) begin
          w = 16'd1;
          h = 16'd1;
          col = rect_color;
          if (frame_len == 8) begin
            col = be24(5);
          end else if (frame_len == 9) begin
            w = le16(5);
            h = le16(7);
          end else if (frame_len >= 12) begin
            w = le16(5);
            h = le16(7);
            col = be24(9);
          end
          rect_color = col;
          hit = 1'b1;
          cmd.kind = KIND_RECT;
          cmd.pos_x = le16(1);
          cmd.pos_y = le16(3);
          cmd.rect_width = w;
          cmd.rect_height = h;
          cmd.fore_color = col;
          if (w >= 4 && h >= 4)
            cmd.region_action = (col == 24'd0) ? ACT_ERASE_BLACK : ACT_HIGHLIGHT;
        end
      end
      CMD_SYS: begin
        hit = 1'b1;
        if (frame_len >= 5) begin
          hw_kind = frame_byte(1);
          fw_version = be24(2);
        end
        if (frame_len >= 6) font_sel = frame_byte(5);
        cmd.kind = KIND_SYS;
      end
      default: ;
    endcase
    if (hit) begin
      cmd.hardware_kind = hw_kind;
      cmd.firmware_version = fw_version;
      cmd.font_setting = font_sel;
      expected_cmds = {expected_cmds, cmd};
    end
  endtask

  task automatic take_rx_byte(logic [7:0] b, logic drop);
    if (drop) begin
      frame_len = '0;
      esc_pending = 1'b0;
    end else if (esc_pending) begin
      if (b == TFEND) store_byte(FEND);
      else if (b == TFESC) store_byte(FESC);
      else store_byte(b);
      esc_pending = 1'b0;
    end else if (b == FESC) begin
      esc_pending = 1'b1;
    end else if (b == FEND) begin
      if (frame_len != 0) begin
        close_frame();
        frame_len = '0;
      end
    end else begin
      store_byte(b);
    end
  endtask

  task automatic compare_field(string name, logic [23:0] exp_val, logic [23:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_KEEP_BYTES_DEF; i++) frame_bytes[i] = 8'h00;
      frame_len = '0;
      esc_pending = 1'b0;
      rect_color = '0;
      hw_kind = '0;
      fw_version = '0;
      font_sel = '0;
      expected_cmds.delete();
      mismatches = 0;
    end else begin
      if (s_tvalid && s_tready) take_rx_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected result item: kind %0d, data 0x%0h", m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          compare_field("kind", 24'(want.kind), 24'(m_tuser));
          compare_field("glyph", 24'(want.glyph), 24'(m_tdata[7:0]));
          compare_field("pos_x", 24'(want.pos_x), 24'(m_tdata[23:8]));
          compare_field("pos_y", 24'(want.pos_y), 24'(m_tdata[39:24]));
          compare_field("rect_width", 24'(want.rect_width), 24'(m_tdata[55:40]));
          compare_field("rect_height", 24'(want.rect_height), 24'(m_tdata[71:56]));
          compare_field("fore_color", want.fore_color, m_tdata[95:72]);
          compare_field("back_color", want.back_color, m_tdata[119:96]);
          compare_field("region_action", 24'(want.region_action), 24'(m_tdata[121:120]));
          compare_field("hardware_kind", 24'(want.hardware_kind), 24'(m_tdata[129:122]));
          compare_field("firmware_version", want.firmware_version, m_tdata[153:130]);
          compare_field("font_setting", 24'(want.font_setting), 24'(m_tdata[161:154]));
          compare_field("zero_fill", 24'd0, 24'(m_tdata[167:162]));
        end
      end
    end
    pending = expected_cmds.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import sdcd_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic [TUSER_IN_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic [TUSER_OUT_W-1:0] m_tuser;

  int         mismatches;
  int         pending;
  int         bytes_sent = 0;
  int         quiet_cycles = 0;
  bit         calm = 1'b0;
  bit         hold_request = 1'b0;
  bit         hold_done = 1'b0;
  logic [7:0] body[$];

  slip_display_command_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  display_command_checker checker_i (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .mismatches(mismatches),
    .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        m_tready = 1'b1;
      end else begin
        m_tready = ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic send_raw(logic [7:0] b, logic drop);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tuser = drop;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (body[i]) begin
      if (body[i] == FEND) begin
        send_raw(FESC, 1'b0);
        send_raw(TFEND, 1'b0);
      end else if (body[i] == FESC) begin
        send_raw(FESC, 1'b0);
        send_raw(TFESC, 1'b0);
      end else begin
        send_raw(body[i], 1'b0);
      end
    end
    send_raw(FEND, 1'b0);
  endtask

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0: b = FEND;
        1: b = FESC;
        2: b = TFEND;
        default: b = TFESC;
      endcase
    end
    return b;
  endfunction

  task automatic send_random_command();
    int len;
    body.delete();
    case ($urandom_range(2))
      0: begin
        body = {body, CMD_CHAR};
        len = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : 12;
      end
      1: begin
        body = {body, CMD_RECT};
        case ($urandom_range(3))
          0: len = 8;
          1: len = 9;
          2: len = 12;
          default: len = $urandom_range(2, 16);
        endcase
      end
      default: begin
        body = {body, CMD_SYS};
        len = $urandom_range(1, 8);
      end
    endcase
    for (int i = 1; i < len; i++) body = {body, rand_byte()};
    if (body[0] == CMD_RECT && len >= 9 && $urandom_range(3) == 0) begin
      body[5] = 8'($urandom_range(6));
      body[6] = 8'h00;
    end
    if (body[0] == CMD_RECT && $urandom_range(3) == 0) begin
      if (len == 8) begin
        body[5] = 8'h00;
        body[6] = 8'h00;
        body[7] = 8'h00;
      end else if (len >= 12) begin
        body[9] = 8'h00;
        body[10] = 8'h00;
        body[11] = 8'h00;
      end
    end
    send_frame();
  endtask

  task automatic send_noise();
    int n;
    case ($urandom_range(4))
      0: begin
        n = $urandom_range(1, 8);
        send_raw(CMD_CHAR, 1'b0);
        for (int i = 0; i < n; i++) send_raw(rand_byte(), 1'b0);
        send_raw(rand_byte(), 1'b1);
      end
      1: begin
        body.delete();
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) body = {body, rand_byte()};
        send_frame();
      end
      2: begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_raw(rand_byte(), $urandom_range(9) == 0);
      end
      3: send_raw(FEND, 1'b0);
      default: begin
        send_raw(FESC, 1'b0);
        send_raw(rand_byte(), 1'b1);
      end
    endcase
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_raw(FEND, 1'b0);
    body = '{CMD_CHAR, 8'h41, 8'h00, 8'h00, 8'hFF, 8'hFF, FEND, FESC, 8'hFF,
             8'h00, 8'h00, 8'h00};
    send_frame();
    body = '{CMD_CHAR, FEND, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
             8'hFF, 8'hFF, 8'hFF};
    send_frame();
    body = '{CMD_CHAR, 8'h42, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
             8'h08, 8'h09};
    send_frame();
    body = '{CMD_RECT, 8'h01, 8'h02, 8'h03};
    send_frame();
    body = '{CMD_RECT, 8'h10, 8'h00, 8'h20, 8'h00, 8'h04, 8'h00, 8'h04, 8'h00,
             8'h00, 8'h00, 8'h00};
    send_frame();
    body = '{CMD_RECT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
             8'hFF, 8'hFF, 8'hFF};
    send_frame();
    body = '{CMD_RECT, 8'h05, 8'h00, 8'h06, 8'h00, 8'h12, 8'h34, 8'h56};
    send_frame();
    body = '{CMD_RECT, 8'h07, 8'h00, 8'h08, 8'h00, 8'h03, 8'h00, 8'h64, 8'h00};
    send_frame();
    body = '{CMD_RECT, 8'h09, 8'h00, 8'h0A, 8'h00};
    send_frame();
    body = '{CMD_RECT, 8'h01, 8'h01, 8'h02, 8'h02, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
    send_frame();
    body = '{CMD_RECT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00, 8'h03, 8'h00,
             8'hAB, 8'hCD, 8'hEF};
    send_frame();
    body = '{CMD_RECT, 8'h11, 8'h22, 8'h33, 8'h44, 8'h20, 8'h00, 8'h30, 8'h00,
             8'h80, 8'h40, 8'h20, 8'hEE, 8'hEE, 8'hEE, 8'hEE, 8'hEE};
    send_frame();
    body = '{CMD_SYS};
    send_frame();
    body = '{CMD_SYS, 8'h0A, 8'h01, 8'h02, 8'h03};
    send_frame();
    body = '{CMD_SYS, 8'h0B, 8'h04, 8'h05, 8'h06, 8'h07};
    send_frame();
    body = '{CMD_SYS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    body = '{8'h42, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_frame();
    // An END right after ESC is kept as data and does not close the frame.
    send_raw(CMD_RECT, 1'b0);
    send_raw(FESC, 1'b0);
    send_raw(FEND, 1'b0);
    send_raw(8'h01, 1'b0);
    send_raw(8'h02, 1'b0);
    send_raw(8'h03, 1'b0);
    send_raw(FEND, 1'b0);
    send_raw(CMD_SYS, 1'b0);
    send_raw(FESC, 1'b0);
    send_raw(8'h41, 1'b0);
    send_raw(FEND, 1'b0);
    send_raw(CMD_CHAR, 1'b0);
    send_raw(8'h01, 1'b0);
    send_raw(FEND, 1'b1);
    send_raw(CMD_SYS, 1'b0);
    send_raw(FESC, 1'b0);
    send_raw(TFEND, 1'b1);
    body = '{CMD_SYS, 8'h5A};
    send_frame();

    hold_request = 1'b1;
    repeat (10) send_random_command();

    calm = 1'b1;
    repeat (10) send_random_command();
    calm = 1'b0;

    while (bytes_sent < 500) begin
      if ($urandom_range(99) < 80) send_random_command();
      else send_noise();
    end

    s_tvalid = 1'b0;
    s_tuser = '0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sdcd_pkg.sv
rtl/sdcd_deframer.sv
rtl/sdcd_decoder.sv
rtl/slip_display_command_decoder_unit.sv
dv/display_command_checker.sv
dv/tb_top.sv
